>>> design/jbdf_pkg.sv
// shared types and constants for the json brace depth framer
package jbdf_pkg;

  localparam int unsigned CNT_W  = 27;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CNT_W-1:0] MAX_BYTES_RESET = CNT_W'(33554432);
  localparam logic [CNT_W-1:0] CNT_SAT         = '1;

  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_NEST_OVF = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_byte;
    logic              first_of_msg;
    logic              last_of_msg;
    status_t           status;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } core_out_t;

endpackage

>>> design/jbdf_in_if.sv
// input byte channel
interface jbdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

>>> design/jbdf_out_if.sv
// result channel
interface jbdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       first_of_msg;
  logic       last_of_msg;
  logic [1:0] status;

  modport source (output valid, output msg_byte, output first_of_msg,
                  output last_of_msg, output status, input ready);
  modport sink (input valid, input msg_byte, input first_of_msg,
                input last_of_msg, input status, output ready);
endinterface

>>> design/json_brace_depth_framer.sv
// top level of the json brace depth framer
//
// cuts json messages out of a byte stream, one byte per request on in_s.
// bytes outside a message are dropped until '{' or '[' opens one; every
// byte of a message then comes out on out_s with first_of_msg on the opener
// and last_of_msg on the matching closer at depth zero. quoted strings and
// backslash escapes are tracked so brackets inside strings do not count.
// a byte count since the last message end above cfg max gives a status 1
// result, an opener past MAX_NESTING gives status 2; both zero the byte
// and return to searching.
// a result appears on out_s in the cycle after its byte is taken.
// throughput: one byte per cycle while out_s is not stalled, set by the single result register.
// in_s.ready is high while the result register is empty or being read, so
// a stall on out_s holds one result and then stops input.
// reset (rst_n low, synchronous) returns to searching, clears the count and sets the limit to
// 33554432; the user must assert cfg_we, which writes the limit, only while idle; the block leaves this unchecked.
module json_brace_depth_framer import jbdf_pkg::*; #(
  parameter int unsigned MAX_NESTING = 255
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  jbdf_in_if.sink          in_s,
  jbdf_out_if.source       out_s
);

  logic [CNT_W-1:0] max_bytes_r;
  logic             space;
  logic             step;
  core_out_t        core_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RESET;
    end else if (cfg_we) begin
      max_bytes_r <= cfg_wdata;
    end
  end

  assign in_s.ready = space;
  assign step       = in_s.valid && space;

  jbdf_core #(
    .MAX_NESTING (MAX_NESTING)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_s.data_byte),
    .max_bytes (max_bytes_r),
    .core_out  (core_out)
  );

  jbdf_out_reg u_out_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (step && core_out.valid),
    .res   (core_out.res),
    .space (space),
    .out_s (out_s)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_s.valid)
    else $error("result valid after reset");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && out_s.status != ST_OK) |->
      (out_s.msg_byte == '0 && !out_s.first_of_msg && !out_s.last_of_msg))
    else $error("error result carries message fields");

  a_first_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_s.valid |-> !(out_s.first_of_msg && out_s.last_of_msg))
    else $error("first and last on one byte");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_s.valid |-> in_s.ready)
    else $error("input stalled with empty result register");

endmodule

>>> design/jbdf_core.sv
// framing state and per-byte decode
module jbdf_core import jbdf_pkg::*; #(
  parameter int unsigned MAX_NESTING = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [CNT_W-1:0]  max_bytes,
  output core_out_t         core_out
);

  localparam int unsigned DEPTH_W = $clog2(MAX_NESTING + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NESTING);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

  logic               inside_r, inside_nxt;
  logic               brace_r, brace_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               quote_r, quote_nxt;
  logic               esc_r, esc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [CNT_W-1:0]   cnt_inc;
  logic [BYTE_W-1:0]  opener, closer;
  logic [DEPTH_W-1:0] depth_dec;

  always_comb begin
    cnt_inc   = (cnt_r == CNT_SAT) ? cnt_r : cnt_r + CNT_W'(1);
    opener    = brace_r ? CH_LBRACE : CH_LBRACK;
    closer    = brace_r ? CH_RBRACE : CH_RBRACK;
    depth_dec = (depth_r != '0) ? depth_r - DEPTH_ONE : depth_r;

    inside_nxt = inside_r;
    brace_nxt  = brace_r;
    depth_nxt  = depth_r;
    quote_nxt  = quote_r;
    esc_nxt    = esc_r;
    cnt_nxt    = cnt_inc;

    core_out.valid            = 1'b0;
    core_out.res.msg_byte     = data_byte;
    core_out.res.first_of_msg = 1'b0;
    core_out.res.last_of_msg  = 1'b0;
    core_out.res.status       = ST_OK;

    if (cnt_inc > max_bytes) begin
      inside_nxt = 1'b0;
      brace_nxt  = 1'b0;
      depth_nxt  = '0;
      quote_nxt  = 1'b0;
      esc_nxt    = 1'b0;
      cnt_nxt    = '0;
      core_out.valid        = 1'b1;
      core_out.res.msg_byte = '0;
      core_out.res.status   = ST_TOO_LONG;
    end else if (!inside_r) begin
      if (data_byte == CH_LBRACE || data_byte == CH_LBRACK) begin
        inside_nxt = 1'b1;
        brace_nxt  = (data_byte == CH_LBRACE);
        depth_nxt  = DEPTH_ONE;
        quote_nxt  = 1'b0;
        esc_nxt    = 1'b0;
        core_out.valid            = 1'b1;
        core_out.res.first_of_msg = 1'b1;
      end
    end else begin
      core_out.valid = 1'b1;
      if (!quote_r) begin
        if (data_byte == opener) begin
          if (depth_r >= DEPTH_MAX) begin
            inside_nxt = 1'b0;
            brace_nxt  = 1'b0;
            depth_nxt  = '0;
            quote_nxt  = 1'b0;
            esc_nxt    = 1'b0;
            cnt_nxt    = '0;
            core_out.res.msg_byte = '0;
            core_out.res.status   = ST_NEST_OVF;
          end else begin
            depth_nxt = depth_r + DEPTH_ONE;
          end
        end else if (data_byte == closer) begin
          depth_nxt = depth_dec;
          if (depth_dec == '0) begin
            inside_nxt = 1'b0;
            brace_nxt  = 1'b0;
            quote_nxt  = 1'b0;
            esc_nxt    = 1'b0;
            cnt_nxt    = '0;
            core_out.res.last_of_msg = 1'b1;
          end
        end else if (data_byte == CH_QUOTE) begin
          quote_nxt = 1'b1;
          esc_nxt   = 1'b0;
        end
      end else begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (data_byte == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (data_byte == CH_QUOTE) begin
          quote_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      brace_r  <= 1'b0;
      depth_r  <= '0;
      quote_r  <= 1'b0;
      esc_r    <= 1'b0;
      cnt_r    <= '0;
    end else if (step) begin
      inside_r <= inside_nxt;
      brace_r  <= brace_nxt;
      depth_r  <= depth_nxt;
      quote_r  <= quote_nxt;
      esc_r    <= esc_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/jbdf_out_reg.sv
// result register in front of the output channel
module jbdf_out_reg import jbdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    res,
  output logic       space,
  jbdf_out_if.source out_s
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign space = !valid_r || out_s.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (space) begin
      valid_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (space && push) begin
      res_r <= res;
    end
  end

  assign out_s.valid        = valid_r;
  assign out_s.msg_byte     = res_r.msg_byte;
  assign out_s.first_of_msg = res_r.first_of_msg;
  assign out_s.last_of_msg  = res_r.last_of_msg;
  assign out_s.status       = res_r.status;

endmodule
